@@ rtl/mid_pkg.sv @@
// Shared types and constants for the MIPS32 instruction decoder.
`timescale 1ns / 1ps
package mid_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned CLASS_W = 7;
	localparam int unsigned REG_W   = 5;
	localparam int unsigned OP_W    = 6;
	localparam int unsigned IMM_W   = 16;
	localparam int unsigned INDEX_W = 26;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CLASS_W-1:0] class_t;
	typedef logic [REG_W-1:0]   reg_t;
	typedef logic [OP_W-1:0]    op_t;

	// Major opcodes that open a group with a minor field.
	localparam op_t OP_SPECIAL  = 6'o00;
	localparam op_t OP_REGIMM   = 6'o01;
	localparam op_t OP_COP0     = 6'o20;
	localparam op_t OP_SPECIAL2 = 6'o34;
	localparam op_t OP_SPECIAL3 = 6'o37;

	// Whole words that decode to a class of their own.
	localparam word_t WORD_NOP = 32'h0000_0000;
	localparam word_t WORD_EHB = 32'h0000_00C0;

	// Class codes and group boundaries.
	localparam class_t CLASS_UNKNOWN        = 7'd0;
	localparam class_t CLASS_COP0_FIRST     = 7'd1;
	localparam class_t CLASS_COP0_LAST      = 7'd2;
	localparam class_t CLASS_SPECIAL_FIRST  = 7'd3;
	localparam class_t CLASS_SPECIAL_LAST   = 7'd39;
	localparam class_t CLASS_SPECIAL2_FIRST = 7'd40;
	localparam class_t CLASS_SPECIAL2_LAST  = 7'd47;
	localparam class_t CLASS_SPECIAL3_FIRST = 7'd48;
	localparam class_t CLASS_SPECIAL3_LAST  = 7'd50;
	localparam class_t CLASS_REGIMM_FIRST   = 7'd51;
	localparam class_t CLASS_REGIMM_LAST    = 7'd65;
	localparam class_t CLASS_STD_FIRST      = 7'd66;
	localparam class_t CLASS_STD_LAST       = 7'd101;
	localparam class_t CLASS_NOP            = 7'd102;
	localparam class_t CLASS_EHB            = 7'd103;

endpackage

@@ rtl/mid_if.sv @@
// Valid/ready channel interfaces for instruction words and decoded results.
`timescale 1ns / 1ps
interface mid_word_if;
	logic           valid;
	logic           ready;
	mid_pkg::word_t instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mid_dec_if;
	logic                          valid;
	logic                          ready;
	mid_pkg::class_t               instruction_class;
	mid_pkg::reg_t                 source_reg;
	mid_pkg::reg_t                 target_reg;
	mid_pkg::reg_t                 dest_reg;
	logic [mid_pkg::INDEX_W-1:0]   jump_target;
	logic [mid_pkg::IMM_W-1:0]     imm_value;
	mid_pkg::reg_t                 shift_amount;
	mid_pkg::op_t                  major_opcode;
	mid_pkg::op_t                  function_code;

	modport source (output valid, output instruction_class, output source_reg,
		output target_reg, output dest_reg, output jump_target, output imm_value,
		output shift_amount, output major_opcode, output function_code, input ready);
	modport sink (input valid, input instruction_class, input source_reg,
		input target_reg, input dest_reg, input jump_target, input imm_value,
		input shift_amount, input major_opcode, input function_code, output ready);
endinterface

@@ rtl/mips32_instruction_decoder.sv @@
// Top level of the MIPS32 instruction decoder: input register, decode, result register.
//
//   Channel   Direction   Payload
//   instr     in          instruction_word (32 bits)
//   decoded   out         instruction_class, source_reg, target_reg, dest_reg,
//                         jump_target, imm_value, shift_amount, major_opcode,
//                         function_code
//
// An accepted word is captured in the input register, decoded by the class lookup while
// it waits there and written to the result register once that register can take it.
// One word is accepted every cycle while the output side keeps taking results; the
// class lookup is combinational, so it does not hold that rate back.
// Reset clears only the two valid flags; payload registers are not reset.
// A stall on the output holds the result register, and the input register fills up
// behind it before instr.ready drops, so no item is dropped or repeated.
`timescale 1ns / 1ps
module mips32_instruction_decoder (
	input logic       clk,
	input logic       arst_n,
	mid_word_if.sink  instr,
	mid_dec_if.source decoded
);

	// Input stage.
	logic           valid_s1;
	mid_pkg::word_t word_s1;

	// Result stage.
	logic                        valid_s2;
	mid_pkg::class_t             class_s2;
	mid_pkg::reg_t               rs_s2;
	mid_pkg::reg_t               rt_s2;
	mid_pkg::reg_t               rd_s2;
	logic [mid_pkg::INDEX_W-1:0] index_s2;
	logic [mid_pkg::IMM_W-1:0]   imm_s2;
	mid_pkg::reg_t               shamt_s2;
	mid_pkg::op_t                op_s2;
	mid_pkg::op_t                fn_s2;

	logic            ready_s1;
	logic            ready_s2;
	logic            zero_fields;
	mid_pkg::class_t dec_class;
	mid_pkg::word_t  field_word;

	// The result register takes a new item when empty or when its item leaves;
	// the input register moves on whenever the result register can take its item.
	assign ready_s2    = !valid_s2 || decoded.ready;
	assign ready_s1    = !valid_s1 || ready_s2;
	assign instr.ready = ready_s1;

	mid_class_dec u_class_dec (
		.word        (word_s1),
		.instr_class (dec_class)
	);

	// NOP and EHB report their class with every field cleared.
	assign zero_fields = (word_s1 == mid_pkg::WORD_NOP) || (word_s1 == mid_pkg::WORD_EHB);
	assign field_word  = zero_fields ? '0 : word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= instr.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (instr.valid && ready_s1) begin
			word_s1 <= instr.instruction_word;
		end
		if (valid_s1 && ready_s2) begin
			class_s2 <= dec_class;
			rs_s2    <= field_word[25:21];
			rt_s2    <= field_word[20:16];
			rd_s2    <= field_word[15:11];
			index_s2 <= field_word[25:0];
			imm_s2   <= field_word[15:0];
			shamt_s2 <= field_word[10:6];
			op_s2    <= field_word[31:26];
			fn_s2    <= field_word[5:0];
		end
	end

	assign decoded.valid             = valid_s2;
	assign decoded.instruction_class = class_s2;
	assign decoded.source_reg        = rs_s2;
	assign decoded.target_reg        = rt_s2;
	assign decoded.dest_reg          = rd_s2;
	assign decoded.jump_target       = index_s2;
	assign decoded.imm_value         = imm_s2;
	assign decoded.shift_amount      = shamt_s2;
	assign decoded.major_opcode      = op_s2;
	assign decoded.function_code     = fn_s2;

`ifndef SYNTHESIS
	// A word taken in always occupies the input register in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		instr.valid && ready_s1 |=> valid_s1)
		else $error("accepted word did not reach the input register");

	// A waiting input item is neither lost nor changed while the result side stalls.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(word_s1))
		else $error("input register changed while stalled");

	// Class codes stay within the defined range.
	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> class_s2 <= mid_pkg::CLASS_EHB)
		else $error("class code out of range");

	// NOP and EHB carry only zero fields.
	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (class_s2 == mid_pkg::CLASS_NOP || class_s2 == mid_pkg::CLASS_EHB)
		|-> op_s2 == '0 && index_s2 == '0 && fn_s2 == '0)
		else $error("NOP or EHB result with nonzero fields");

	// A SPECIAL class always comes with the SPECIAL major opcode.
	a_special_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && class_s2 >= mid_pkg::CLASS_SPECIAL_FIRST
		&& class_s2 <= mid_pkg::CLASS_SPECIAL_LAST |-> op_s2 == mid_pkg::OP_SPECIAL)
		else $error("SPECIAL class with a different major opcode");
`endif

endmodule

@@ rtl/mid_class_dec.sv @@
// Combinational mnemonic class lookup for one MIPS32 instruction word.
`timescale 1ns / 1ps
module mid_class_dec (
	input  mid_pkg::word_t  word,
	output mid_pkg::class_t instr_class
);

	mid_pkg::op_t  op;
	mid_pkg::op_t  fn;
	mid_pkg::reg_t rs;
	mid_pkg::reg_t rt;
	mid_pkg::class_t group_class;

	assign op = word[31:26];
	assign fn = word[5:0];
	assign rs = word[25:21];
	assign rt = word[20:16];

	always_comb begin
		group_class = mid_pkg::CLASS_UNKNOWN;
		unique case (op)
			mid_pkg::OP_SPECIAL: begin
				unique case (fn)
					6'o00: group_class = 7'd3;
					6'o02: group_class = 7'd4;
					6'o03: group_class = 7'd5;
					6'o04: group_class = 7'd6;
					6'o06: group_class = 7'd7;
					6'o07: group_class = 7'd8;
					6'o10: group_class = 7'd9;
					6'o11: group_class = 7'd10;
					6'o12: group_class = 7'd11;
					6'o13: group_class = 7'd12;
					6'o14: group_class = 7'd13;
					6'o15: group_class = 7'd14;
					6'o17: group_class = 7'd15;
					6'o20: group_class = 7'd16;
					6'o21: group_class = 7'd17;
					6'o22: group_class = 7'd18;
					6'o23: group_class = 7'd19;
					6'o30: group_class = 7'd20;
					6'o31: group_class = 7'd21;
					6'o32: group_class = 7'd22;
					6'o33: group_class = 7'd23;
					6'o40: group_class = 7'd24;
					6'o41: group_class = 7'd25;
					6'o42: group_class = 7'd26;
					6'o43: group_class = 7'd27;
					6'o44: group_class = 7'd28;
					6'o45: group_class = 7'd29;
					6'o46: group_class = 7'd30;
					6'o47: group_class = 7'd31;
					6'o52: group_class = 7'd32;
					6'o53: group_class = 7'd33;
					6'o60: group_class = 7'd34;
					6'o61: group_class = 7'd35;
					6'o62: group_class = 7'd36;
					6'o63: group_class = 7'd37;
					6'o64: group_class = 7'd38;
					6'o66: group_class = 7'd39;
					default: group_class = mid_pkg::CLASS_UNKNOWN;
				endcase
			end
			mid_pkg::OP_REGIMM: begin
				unique case (rt)
					5'o00: group_class = 7'd51;
					5'o01: group_class = 7'd52;
					5'o02: group_class = 7'd53;
					5'o03: group_class = 7'd54;
					5'o10: group_class = 7'd55;
					5'o11: group_class = 7'd56;
					5'o12: group_class = 7'd57;
					5'o13: group_class = 7'd58;
					5'o14: group_class = 7'd59;
					5'o16: group_class = 7'd60;
					5'o20: group_class = 7'd61;
					5'o21: group_class = 7'd62;
					5'o22: group_class = 7'd63;
					5'o23: group_class = 7'd64;
					5'o37: group_class = 7'd65;
					default: group_class = mid_pkg::CLASS_UNKNOWN;
				endcase
			end
			mid_pkg::OP_COP0: begin
				unique case (rs)
					5'o00: group_class = 7'd1;
					5'o04: group_class = 7'd2;
					default: group_class = mid_pkg::CLASS_UNKNOWN;
				endcase
			end
			mid_pkg::OP_SPECIAL2: begin
				unique case (fn)
					6'o00: group_class = 7'd40;
					6'o01: group_class = 7'd41;
					6'o02: group_class = 7'd42;
					6'o04: group_class = 7'd43;
					6'o05: group_class = 7'd44;
					6'o40: group_class = 7'd45;
					6'o41: group_class = 7'd46;
					6'o77: group_class = 7'd47;
					default: group_class = mid_pkg::CLASS_UNKNOWN;
				endcase
			end
			mid_pkg::OP_SPECIAL3: begin
				unique case (fn)
					6'o00: group_class = 7'd48;
					6'o04: group_class = 7'd49;
					6'o40: group_class = 7'd50;
					default: group_class = mid_pkg::CLASS_UNKNOWN;
				endcase
			end
			default: begin
				unique case (op)
					6'o02: group_class = 7'd66;
					6'o03: group_class = 7'd67;
					6'o04: group_class = 7'd68;
					6'o05: group_class = 7'd69;
					6'o06: group_class = 7'd70;
					6'o07: group_class = 7'd71;
					6'o10: group_class = 7'd72;
					6'o11: group_class = 7'd73;
					6'o12: group_class = 7'd74;
					6'o13: group_class = 7'd75;
					6'o14: group_class = 7'd76;
					6'o15: group_class = 7'd77;
					6'o16: group_class = 7'd78;
					6'o17: group_class = 7'd79;
					6'o24: group_class = 7'd80;
					6'o25: group_class = 7'd81;
					6'o26: group_class = 7'd82;
					6'o27: group_class = 7'd83;
					6'o40: group_class = 7'd84;
					6'o41: group_class = 7'd85;
					6'o42: group_class = 7'd86;
					6'o43: group_class = 7'd87;
					6'o44: group_class = 7'd88;
					6'o45: group_class = 7'd89;
					6'o46: group_class = 7'd90;
					6'o50: group_class = 7'd91;
					6'o51: group_class = 7'd92;
					6'o52: group_class = 7'd93;
					6'o53: group_class = 7'd94;
					6'o56: group_class = 7'd95;
					6'o57: group_class = 7'd96;
					6'o60: group_class = 7'd97;
					6'o62: group_class = 7'd98;
					6'o63: group_class = 7'd99;
					6'o70: group_class = 7'd100;
					6'o72: group_class = 7'd101;
					default: group_class = mid_pkg::CLASS_UNKNOWN;
				endcase
			end
		endcase
	end

	// The two whole-word encodings override the group lookup.
	always_comb begin
		priority if (word == mid_pkg::WORD_NOP) begin
			instr_class = mid_pkg::CLASS_NOP;
		end else if (word == mid_pkg::WORD_EHB) begin
			instr_class = mid_pkg::CLASS_EHB;
		end else begin
			instr_class = group_class;
		end
	end

endmodule

@@ tb/mips32_instruction_decoder_tb.sv @@
// Self-checking testbench for the MIPS32 instruction decoder with random flow control.
`timescale 1ns / 1ps
module mips32_instruction_decoder_tb;
	import mid_pkg::*;

	// Expected contents of one decoded result item.
	typedef struct packed {
		class_t                 instruction_class;
		reg_t                   source_reg;
		reg_t                   target_reg;
		reg_t                   dest_reg;
		logic [INDEX_W-1:0]     jump_target;
		logic [IMM_W-1:0]       imm_value;
		reg_t                   shift_amount;
		op_t                    major_opcode;
		op_t                    function_code;
	} decode_t;

	// Minor code, or major opcode for the standard group, that selects each class.
	// The table is indexed by class, so a group is the class range between its
	// first and last class codes from the package.
	localparam op_t MINOR_CODE [CLASS_COP0_FIRST:CLASS_STD_LAST] = '{
		// COP0, selected by rs.
		6'o00, 6'o04,
		// SPECIAL, selected by funct.
		6'o00, 6'o02, 6'o03, 6'o04, 6'o06, 6'o07, 6'o10, 6'o11, 6'o12, 6'o13,
		6'o14, 6'o15, 6'o17, 6'o20, 6'o21, 6'o22, 6'o23, 6'o30, 6'o31, 6'o32,
		6'o33, 6'o40, 6'o41, 6'o42, 6'o43, 6'o44, 6'o45, 6'o46, 6'o47, 6'o52,
		6'o53, 6'o60, 6'o61, 6'o62, 6'o63, 6'o64, 6'o66,
		// SPECIAL2, selected by funct.
		6'o00, 6'o01, 6'o02, 6'o04, 6'o05, 6'o40, 6'o41, 6'o77,
		// SPECIAL3, selected by funct.
		6'o00, 6'o04, 6'o40,
		// REGIMM, selected by rt.
		6'o00, 6'o01, 6'o02, 6'o03, 6'o10, 6'o11, 6'o12, 6'o13, 6'o14, 6'o16,
		6'o20, 6'o21, 6'o22, 6'o23, 6'o37,
		// Standard instructions, selected by the major opcode itself.
		6'o02, 6'o03, 6'o04, 6'o05, 6'o06, 6'o07, 6'o10, 6'o11, 6'o12, 6'o13,
		6'o14, 6'o15, 6'o16, 6'o17, 6'o24, 6'o25, 6'o26, 6'o27, 6'o40, 6'o41,
		6'o42, 6'o43, 6'o44, 6'o45, 6'o46, 6'o50, 6'o51, 6'o52, 6'o53, 6'o56,
		6'o57, 6'o60, 6'o62, 6'o63, 6'o70, 6'o72
	};

	// Codes that no group lists, used to provoke the unknown class on purpose.
	localparam op_t OP_UNLISTED     = 6'o61;
	localparam op_t FUNCT_UNLISTED  = 6'o01;
	localparam op_t FUNCT2_UNLISTED = 6'o03;
	localparam op_t FUNCT3_UNLISTED = 6'o01;
	localparam reg_t RT_UNLISTED    = 5'o04;
	localparam reg_t RS_UNLISTED    = 5'o01;

	localparam int unsigned RANDOM_WORDS = 1130;
	localparam int unsigned DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;

	mid_word_if instr ();
	mid_dec_if  decoded ();

	mips32_instruction_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr),
		.decoded (decoded)
	);

	word_t       pending_words [$];
	decode_t     expected_decodes [$];
	int unsigned failures;
	bit          word_accepted;
	int unsigned send_gap;
	int unsigned take_hold;
	bit          send_calm;
	bit          take_calm;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Search one group of the class table for a minor code. A miss gives the
	// unknown class, just as an unlisted encoding does in the hardware.
	function automatic class_t find_class(op_t key, class_t first, class_t last);
		for (int c = first; c <= last; c++) begin
			if (MINOR_CODE[c] == key)
				return class_t'(c);
		end
		return CLASS_UNKNOWN;
	endfunction

	// Predicted result for one instruction word. The fields are plain bit slices;
	// only the class needs a lookup, and the two whole-word special cases (the
	// NOP word and the EHB hazard barrier) force every field to zero.
	function automatic decode_t decode_word(word_t w);
		decode_t d;
		op_t     op;
		d = '0;
		if (w == WORD_NOP || w == WORD_EHB) begin
			d.instruction_class = (w == WORD_NOP) ? CLASS_NOP : CLASS_EHB;
			return d;
		end
		op = w[31:26];
		d.source_reg    = w[25:21];
		d.target_reg    = w[20:16];
		d.dest_reg      = w[15:11];
		d.jump_target   = w[25:0];
		d.imm_value     = w[15:0];
		d.shift_amount  = w[10:6];
		d.major_opcode  = op;
		d.function_code = w[5:0];
		case (op)
			OP_SPECIAL: begin
				d.instruction_class = find_class(w[5:0], CLASS_SPECIAL_FIRST, CLASS_SPECIAL_LAST);
			end
			OP_REGIMM: begin
				d.instruction_class = find_class({1'b0, w[20:16]}, CLASS_REGIMM_FIRST,
					CLASS_REGIMM_LAST);
			end
			OP_COP0: begin
				d.instruction_class = find_class({1'b0, w[25:21]}, CLASS_COP0_FIRST,
					CLASS_COP0_LAST);
			end
			OP_SPECIAL2: begin
				d.instruction_class = find_class(w[5:0], CLASS_SPECIAL2_FIRST,
					CLASS_SPECIAL2_LAST);
			end
			OP_SPECIAL3: begin
				d.instruction_class = find_class(w[5:0], CLASS_SPECIAL3_FIRST,
					CLASS_SPECIAL3_LAST);
			end
			default: begin
				d.instruction_class = find_class(op, CLASS_STD_FIRST, CLASS_STD_LAST);
			end
		endcase
		return d;
	endfunction

	// Random instruction word. Most words are valid encodings of a random class
	// with random operand bits, some of them sparse so that words close to the
	// NOP and EHB patterns turn up. The rest are the two special words, group
	// opcodes with a random minor field, and fully random words.
	function automatic word_t random_word();
		word_t       w;
		int unsigned roll;
		class_t      cls;
		roll = $urandom_range(0, 99);
		w = $urandom;
		if ($urandom_range(0, 3) == 0)
			w = w & $urandom & $urandom;
		if (roll < 70) begin
			cls = class_t'($urandom_range(CLASS_COP0_FIRST, CLASS_STD_LAST));
			if (cls <= CLASS_COP0_LAST) begin
				w[31:26] = OP_COP0;
				w[25:21] = MINOR_CODE[cls][4:0];
			end else if (cls <= CLASS_SPECIAL_LAST) begin
				w[31:26] = OP_SPECIAL;
				w[5:0]   = MINOR_CODE[cls];
			end else if (cls <= CLASS_SPECIAL2_LAST) begin
				w[31:26] = OP_SPECIAL2;
				w[5:0]   = MINOR_CODE[cls];
			end else if (cls <= CLASS_SPECIAL3_LAST) begin
				w[31:26] = OP_SPECIAL3;
				w[5:0]   = MINOR_CODE[cls];
			end else if (cls <= CLASS_REGIMM_LAST) begin
				w[31:26] = OP_REGIMM;
				w[20:16] = MINOR_CODE[cls][4:0];
			end else begin
				w[31:26] = MINOR_CODE[cls];
			end
		end else if (roll < 76) begin
			w = $urandom_range(0, 1) ? WORD_NOP : WORD_EHB;
		end else if (roll < 88) begin
			case ($urandom_range(0, 4))
				0: w[31:26] = OP_SPECIAL;
				1: w[31:26] = OP_REGIMM;
				2: w[31:26] = OP_COP0;
				3: w[31:26] = OP_SPECIAL2;
				default: w[31:26] = OP_SPECIAL3;
			endcase
		end
		return w;
	endfunction

	// Length of the next idle stretch: mostly none or short, now and then long.
	// In a calm phase there is no idling at all.
	function automatic int unsigned pick_gap(bit calm);
		int unsigned roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (actual !== expected) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
			failures++;
		end
	endtask

	// Word driver. It runs on the falling edge, so the decoder sees stable inputs
	// at every rising edge. A word stays on the channel until the monitor has seen
	// it taken; only then may a gap follow or the next word be presented. The
	// valid and payload values are worked out first and assigned once per edge.
	always @(negedge clk) begin : word_driver
		logic  next_valid;
		word_t next_word;
		next_valid = instr.valid;
		next_word  = instr.instruction_word;
		if ($urandom_range(0, 199) == 0)
			send_calm = !send_calm;
		if (arst_n && (!instr.valid || word_accepted)) begin
			next_valid = 1'b0;
			next_word  = $urandom;
			if (send_gap > 0) begin
				send_gap--;
			end else if (pending_words.size() > 0) begin
				next_valid = 1'b1;
				next_word  = pending_words.pop_front();
				send_gap   = pick_gap(send_calm);
			end
		end
		instr.valid            <= next_valid;
		instr.instruction_word <= next_word;
	end

	// Result side back-pressure, also on the falling edge. Stalls start at random
	// and last for a gap drawn the same way as on the sending side.
	always @(negedge clk) begin : result_ready
		if ($urandom_range(0, 199) == 0)
			take_calm = !take_calm;
		if (take_hold > 0) begin
			take_hold--;
			decoded.ready <= 1'b0;
		end else begin
			decoded.ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				take_hold = pick_gap(take_calm);
		end
	end

	// Monitor on the rising edge. Every accepted word queues its predicted
	// decode; every accepted result item is matched against the oldest one.
	always @(posedge clk) begin : monitor
		decode_t want;
		word_accepted = arst_n && instr.valid && instr.ready;
		if (word_accepted)
			expected_decodes.push_back(decode_word(instr.instruction_word));
		if (arst_n && decoded.valid && decoded.ready) begin
			if (expected_decodes.size() == 0) begin
				$error("unexpected result item: class 0x%0h", decoded.instruction_class);
				failures++;
			end else begin
				want = expected_decodes.pop_front();
				check_field("instruction_class", 32'(want.instruction_class),
					32'(decoded.instruction_class));
				check_field("source_reg", 32'(want.source_reg), 32'(decoded.source_reg));
				check_field("target_reg", 32'(want.target_reg), 32'(decoded.target_reg));
				check_field("dest_reg", 32'(want.dest_reg), 32'(decoded.dest_reg));
				check_field("jump_target", 32'(want.jump_target),
					32'(decoded.jump_target));
				check_field("imm_value", 32'(want.imm_value), 32'(decoded.imm_value));
				check_field("shift_amount", 32'(want.shift_amount),
					32'(decoded.shift_amount));
				check_field("major_opcode", 32'(want.major_opcode),
					32'(decoded.major_opcode));
				check_field("function_code", 32'(want.function_code),
					32'(decoded.function_code));
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		clk                    = 1'b0;
		arst_n                 = 1'b0;
		instr.valid            = 1'b0;
		instr.instruction_word = '0;
		decoded.ready          = 1'b0;
		failures               = 0;
		word_accepted          = 1'b0;
		send_gap               = 0;
		take_hold              = 0;
		send_calm              = 1'b0;
		take_calm              = 1'b0;

		// Directed words: the two special whole words and close neighbors, field extremes,
		// both group ends (last only for SPECIAL, SPECIAL3) and an unlisted code in each.
		pending_words.push_back(WORD_NOP);
		pending_words.push_back(WORD_EHB);
		pending_words.push_back(WORD_EHB | word_t'(1));
		pending_words.push_back(word_t'(WORD_EHB) >> 1);
		pending_words.push_back('1);
		pending_words.push_back({OP_SPECIAL, 26'h3ff_ffff});
		pending_words.push_back({OP_SPECIAL, 20'h0, MINOR_CODE[CLASS_SPECIAL_LAST]});
		pending_words.push_back({OP_SPECIAL, 20'h0, FUNCT_UNLISTED});
		pending_words.push_back({OP_COP0, 5'(MINOR_CODE[CLASS_COP0_FIRST]), 21'h1f_ffff});
		pending_words.push_back({OP_COP0, 5'(MINOR_CODE[CLASS_COP0_LAST]), 21'h0});
		pending_words.push_back({OP_COP0, RS_UNLISTED, 21'h0});
		pending_words.push_back({OP_SPECIAL2, 20'h0, MINOR_CODE[CLASS_SPECIAL2_FIRST]});
		pending_words.push_back({OP_SPECIAL2, 20'hf_ffff, MINOR_CODE[CLASS_SPECIAL2_LAST]});
		pending_words.push_back({OP_SPECIAL2, 20'h0, FUNCT2_UNLISTED});
		pending_words.push_back({OP_SPECIAL3, 20'h0, MINOR_CODE[CLASS_SPECIAL3_LAST]});
		pending_words.push_back({OP_SPECIAL3, 20'hf_ffff, FUNCT3_UNLISTED});
		pending_words.push_back({OP_REGIMM, 5'h1f, 5'(MINOR_CODE[CLASS_REGIMM_LAST]),
			16'hffff});
		pending_words.push_back({OP_REGIMM, 5'h0, 5'(MINOR_CODE[CLASS_REGIMM_FIRST]), 16'h0});
		pending_words.push_back({OP_REGIMM, 5'h0, RT_UNLISTED, 16'h8000});
		pending_words.push_back({MINOR_CODE[CLASS_STD_FIRST], 26'h3ff_ffff});
		pending_words.push_back({MINOR_CODE[CLASS_STD_LAST], 26'h0});
		pending_words.push_back({OP_UNLISTED, 26'h155_5555});
		pending_words.push_back({6'h3f, 26'h0});
		pending_words.push_back(word_t'(16'hffff));

		for (int i = 0; i < RANDOM_WORDS; i++)
			pending_words.push_back(random_word());

		// Reset is applied once and released on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every word to be taken and every decode to come back, then let
		// the pipeline run a little longer so that a stray extra result is caught.
		while (pending_words.size() > 0 || instr.valid || expected_decodes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && expected_decodes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
